// ===== rtl/scytale_transposition_assert.svh =====
// ----------------------------------------------------------------------------
// scytale transposition assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SCYTALE_TRANSPOSITION_ASSERT_SVH
`define SCYTALE_TRANSPOSITION_ASSERT_SVH

// antecedent in one cycle implies consequent in the next, outside reset
`define SCYT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent holds in the cycle after any cycle in reset
`define SCYT_ASSERT_AFTER_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scyt_pkg.sv =====
// ----------------------------------------------------------------------------
// scyt_pkg
// types and constants shared by the scytale transposition modules
// ----------------------------------------------------------------------------
package scyt_pkg;

    localparam int CHAR_W     = 8;
    localparam int DIM_W      = 4;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // one completed grid waiting for readout
    typedef struct packed {
        logic             bank;
        logic             mode;
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nc;
    } t_job;

    // readout finished with a bank
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

// ===== rtl/scytale_transposition.sv =====
// ----------------------------------------------------------------------------
// scytale_transposition
// block transposition cipher over a rows by cols grid, spaces dropped
//
//   channel   dir   handshake          payload
//   input     in    i_valid/o_ready    i_char_in
//   output    out   o_valid/i_ready    o_char_out, o_last_out
//   config    in    i_cfg_we           i_cfg_idx, i_cfg_data
//
// loading accepts one character per cycle while the current bank is free
// readout pace is set by the ram read latency against the two-entry output
// buffer and by the receiver; a block of rows*cols characters drains while
// the next block loads
// two ram banks: input stalls only when both banks hold unread grids
// reset clears counters, bank flags and queues; the grid ram needs no clearing
// ----------------------------------------------------------------------------
module scytale_transposition #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scyt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scyt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [scyt_pkg::CHAR_W-1:0]     i_char_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [scyt_pkg::CHAR_W-1:0]     o_char_out,
    output logic                            o_last_out
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int CELL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        wr_en;
    logic [CELL_W:0]             wr_addr;
    logic [scyt_pkg::CHAR_W-1:0] wr_data;
    logic [CELL_W:0]             rd_addr;
    logic [scyt_pkg::CHAR_W-1:0] rd_data;
    logic                        job_push;
    scyt_pkg::t_job              job_in;
    logic                        job_valid;
    logic                        job_pop;
    scyt_pkg::t_job              job_out;
    scyt_pkg::t_release          release_bank;

    scyt_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .CELL_W   (CELL_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_char_in  (i_char_in),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_release  (release_bank)
    );

    scyt_ram #(
        .WIDTH (scyt_pkg::CHAR_W),
        .DEPTH (2 ** (CELL_W + 1))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    scyt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_valid (job_valid),
        .i_pop   (job_pop),
        .o_job   (job_out)
    );

    scyt_back #(
        .CELL_W (CELL_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_release   (release_bank),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_out  (o_char_out),
        .o_last_out  (o_last_out)
    );

endmodule

// ===== rtl/scyt_ram.sv =====
// ----------------------------------------------------------------------------
// scyt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module scyt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scyt_front.sv =====
// ----------------------------------------------------------------------------
// scyt_front
// config registers, space filter and grid loading into the free bank
// ----------------------------------------------------------------------------
module scyt_front #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    parameter int CELL_W   = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [scyt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [scyt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [scyt_pkg::CHAR_W-1:0]        i_char_in,
    output logic                               o_wr_en,
    output logic [CELL_W:0]                    o_wr_addr,
    output logic [scyt_pkg::CHAR_W-1:0]        o_wr_data,
    output logic                               o_job_push,
    output scyt_pkg::t_job                     o_job,
    input  scyt_pkg::t_release                 i_release
);

    logic [scyt_pkg::DIM_W-1:0] r_rows;
    logic [scyt_pkg::DIM_W-1:0] r_cols;
    logic                       r_mode;
    logic [scyt_pkg::CNT_W-1:0] r_load;
    logic                       r_bank;
    logic [1:0]                 r_busy;

    logic [scyt_pkg::DIM_W-1:0] nr;
    logic [scyt_pkg::DIM_W-1:0] nc;
    logic [scyt_pkg::CNT_W-1:0] total;
    logic [scyt_pkg::CNT_W-1:0] slot;
    logic                       keep;
    logic                       done;
    logic                       cfg_hit;
    logic [1:0]                 n_busy;

    function automatic logic [scyt_pkg::DIM_W-1:0] clamp_dim(
        input logic [scyt_pkg::DIM_W-1:0] v,
        input int unsigned                maxv
    );
        logic [scyt_pkg::DIM_W-1:0] res;
        if (v == '0) begin
            res = scyt_pkg::DIM_W'(1);
        end else if (32'(v) > maxv) begin
            res = scyt_pkg::DIM_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

    always_comb begin
        nr    = clamp_dim(r_rows, MAX_ROWS);
        nc    = clamp_dim(r_cols, MAX_COLS);
        total = {4'd0, nr} * {4'd0, nc};
        keep  = i_valid && o_ready && (i_char_in != scyt_pkg::SPACE_CHAR);
        slot  = (r_load >= total) ? '0 : r_load;
        done  = keep && ((slot + 8'd1) == total);

        unique case (i_cfg_idx) inside
            scyt_pkg::CFG_ROWS, scyt_pkg::CFG_COLS, scyt_pkg::CFG_MODE: cfg_hit = i_cfg_we;
            default:                                                   cfg_hit = 1'b0;
        endcase

        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (done) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= scyt_pkg::DIM_W'(1);
            r_cols <= scyt_pkg::DIM_W'(1);
            r_mode <= scyt_pkg::MODE_ENC;
            r_load <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    scyt_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                    scyt_pkg::CFG_COLS: r_cols <= i_cfg_data;
                    scyt_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_load <= '0;
            end else if (keep) begin
                r_load <= done ? '0 : slot + 8'd1;
            end
            if (done) begin
                r_bank <= ~r_bank;
            end
        end
    end

    assign o_ready    = !r_busy[r_bank];
    assign o_wr_en    = keep;
    assign o_wr_addr  = {r_bank, CELL_W'(slot)};
    assign o_wr_data  = i_char_in;
    assign o_job_push = done;
    assign o_job      = '{bank: r_bank, mode: r_mode, nr: nr, nc: nc};

endmodule

// ===== rtl/scyt_queue.sv =====
// ----------------------------------------------------------------------------
// scyt_queue
// two-entry job queue between loading and readout
// ----------------------------------------------------------------------------
module scyt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scyt_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_pop,
    output scyt_pkg::t_job o_job
);

    scyt_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

endmodule

// ===== rtl/scyt_back.sv =====
// ----------------------------------------------------------------------------
// scyt_back
// readout sequencer: walks a grid in transposed order into an output buffer
// ----------------------------------------------------------------------------
module scyt_back #(
    parameter int CELL_W = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  scyt_pkg::t_job              i_job,
    output logic                        o_job_pop,
    output logic [CELL_W:0]             o_rd_addr,
    input  logic [scyt_pkg::CHAR_W-1:0] i_rd_data,
    output scyt_pkg::t_release          o_release,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [scyt_pkg::CHAR_W-1:0] o_char_out,
    output logic                        o_last_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                       r_state;
    logic                       r_bank;
    logic [scyt_pkg::DIM_W-1:0] r_outer_n;
    logic [scyt_pkg::DIM_W-1:0] r_inner_n;
    logic [scyt_pkg::DIM_W-1:0] r_stride;
    logic [scyt_pkg::DIM_W-1:0] r_outer;
    logic [scyt_pkg::DIM_W-1:0] r_inner;
    logic [scyt_pkg::CNT_W-1:0] r_addr;
    logic                       r_rd_vld;
    logic                       r_rd_last;

    logic [scyt_pkg::CHAR_W-1:0] r_ob_char [2];
    logic                        r_ob_last [2];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_occ;

    logic room;
    logic issue;
    logic inner_end;
    logic outer_end;
    logic last_rd;
    logic pop;

    always_comb begin
        // occupancy plus the read in flight must leave a free slot
        room      = (r_occ + {1'b0, r_rd_vld}) < 2'd2;
        issue     = (r_state == ST_RUN) && room;
        inner_end = r_inner == (r_inner_n - 4'd1);
        outer_end = r_outer == (r_outer_n - 4'd1);
        last_rd   = inner_end && outer_end;
        pop       = (r_occ != 2'd0) && i_ready;
    end

    assign o_job_pop  = (r_state == ST_IDLE) && i_job_valid;
    assign o_rd_addr  = {r_bank, CELL_W'(r_addr)};
    assign o_release  = '{valid: issue && last_rd, bank: r_bank};
    assign o_valid    = r_occ != 2'd0;
    assign o_char_out = r_ob_char[r_rp];
    assign o_last_out = r_ob_last[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_occ    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (issue && last_rd) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            r_rd_vld <= issue;
            if (r_rd_vld) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_occ <= r_occ + {1'b0, r_rd_vld} - {1'b0, pop};
        end
    end

    // walk position, meaningful only while running
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_bank  <= i_job.bank;
            r_outer <= '0;
            r_inner <= '0;
            r_addr  <= '0;
            if (i_job.mode == scyt_pkg::MODE_ENC) begin
                // filled by rows, read down each column
                r_outer_n <= i_job.nc;
                r_inner_n <= i_job.nr;
                r_stride  <= i_job.nc;
            end else begin
                r_outer_n <= i_job.nr;
                r_inner_n <= i_job.nc;
                r_stride  <= i_job.nr;
            end
        end else if (issue) begin
            if (inner_end) begin
                r_inner <= '0;
                r_outer <= r_outer + 4'd1;
                r_addr  <= {4'd0, r_outer} + 8'd1;
            end else begin
                r_inner <= r_inner + 4'd1;
                r_addr  <= r_addr + {4'd0, r_stride};
            end
        end
        r_rd_last <= last_rd;
        if (r_rd_vld) begin
            r_ob_char[r_wp] <= i_rd_data;
            r_ob_last[r_wp] <= r_rd_last;
        end
    end

endmodule

// ===== rtl/scyt_checker.sv =====
// ----------------------------------------------------------------------------
// scyt_checker
// port-level checks on the scytale transposition top level
// ----------------------------------------------------------------------------
`include "scytale_transposition_assert.svh"

module scyt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [scyt_pkg::CHAR_W-1:0] o_char_out,
    input logic                        o_last_out
);

    // a stalled output transaction stays offered
    `SCYT_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "output valid dropped while stalled")

    // and its payload does not move
    `SCYT_ASSERT_NEXT(a_out_stable, o_valid && !i_ready, $stable(o_char_out) && $stable(o_last_out), "output payload changed while stalled")

    // nothing left to emit after reset
    `SCYT_ASSERT_AFTER_RST(a_rst_out, !o_valid, "output valid after reset")

    // both grid banks free after reset
    `SCYT_ASSERT_AFTER_RST(a_rst_in, o_ready, "input not ready after reset")

endmodule

bind scytale_transposition scyt_checker u_chk (.*);

// ===== sim/scyt_text_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scyt_text_checker
// watches the config port and both channels of the scytale block, keeps its
// own grid and settings, predicts every transposed character and compares
// each output transaction against the oldest prediction
// ----------------------------------------------------------------------------
module scyt_text_checker #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [scyt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scyt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [scyt_pkg::CHAR_W-1:0]     i_in_char,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [scyt_pkg::CHAR_W-1:0]     i_out_char,
    input  logic                            i_out_last,
    output int                              o_errors,
    output int                              o_pending
);

    localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;

    typedef struct packed {
        logic [scyt_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_text_beat;

    logic [scyt_pkg::DIM_W-1:0]  rows_q;
    logic [scyt_pkg::DIM_W-1:0]  cols_q;
    logic                        mode_q;
    logic [scyt_pkg::CHAR_W-1:0] grid_q [GRID_CELLS];
    int                          fill_cnt;
    int                          out_cnt;
    t_text_beat                  cipher_q [$];

    // zero reads as one, anything above the maximum saturates
    function automatic int eff_dim(input logic [scyt_pkg::DIM_W-1:0] raw, input int max_dim);
        if (raw == '0)
            return 1;
        if (int'(raw) > max_dim)
            return max_dim;
        return int'(raw);
    endfunction

    task automatic absorb_char(input logic [scyt_pkg::CHAR_W-1:0] ch);
        int         nr;
        int         nc;
        int         total;
        int         k;
        int         idx;
        t_text_beat beat;
        nr    = eff_dim(rows_q, MAX_ROWS);
        nc    = eff_dim(cols_q, MAX_COLS);
        total = nr * nc;
        if (ch != scyt_pkg::SPACE_CHAR) begin
            if (fill_cnt >= total)
                fill_cnt = 0;
            grid_q[fill_cnt] = ch;
            fill_cnt++;
            if (fill_cnt >= total) begin
                for (k = 0; k < total; k++) begin
                    // encrypt: row-major fill, column-major read; decrypt the reverse
                    if (mode_q == scyt_pkg::MODE_ENC)
                        idx = (k % nr) * nc + k / nr;
                    else
                        idx = (k % nc) * nr + k / nc;
                    beat.ch   = grid_q[idx];
                    beat.last = (k == total - 1);
                    cipher_q.push_back(beat);
                end
                fill_cnt = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_text_beat want;
        if (!i_rst_n) begin
            rows_q   = 4'd1;
            cols_q   = 4'd1;
            mode_q   = scyt_pkg::MODE_ENC;
            fill_cnt = 0;
            out_cnt  = 0;
            o_errors = 0;
            cipher_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    scyt_pkg::CFG_ROWS: begin
                        rows_q   = i_cfg_data;
                        fill_cnt = 0;
                    end
                    scyt_pkg::CFG_COLS: begin
                        cols_q   = i_cfg_data;
                        fill_cnt = 0;
                    end
                    scyt_pkg::CFG_MODE: begin
                        mode_q   = i_cfg_data[0];
                        fill_cnt = 0;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("output %0d unexpected: char %02h last %0b",
                                 out_cnt, i_out_char, i_out_last);
                end else begin
                    want = cipher_q.pop_front();
                    if (want.ch !== i_out_char || want.last !== i_out_last) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"output %0d: expected char %02h last %0b, ",
                                      "got char %02h last %0b"},
                                     out_cnt, want.ch, want.last, i_out_char, i_out_last);
                    end
                end
                out_cnt++;
            end
            if (i_in_valid && i_in_ready)
                absorb_char(i_in_char);
        end
        o_pending = cipher_q.size();
    end

endmodule

// ===== sim/tb_scytale_transposition.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scytale_transposition
// drives text into the scytale block under many grid shapes and both modes,
// with bursty input, a stalling receiver and one long output hold-off;
// the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_scytale_transposition;

    localparam int MAX_ROWS       = 8;
    localparam int MAX_COLS       = 8;
    localparam int KEPT_TARGET    = 250;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 200;

    localparam logic [scyt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [scyt_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [scyt_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid    = 1'b0;
    logic                            o_ready;
    logic [scyt_pkg::CHAR_W-1:0]     i_char_in  = '0;
    logic                            o_valid;
    logic                            i_ready    = 1'b0;
    logic [scyt_pkg::CHAR_W-1:0]     o_char_out;
    logic                            o_last_out;

    int fault_cnt;
    int pending_cnt;
    int stall_cycles = 0;
    int burst_left   = 0;
    bit gap_free     = 1'b0;
    int kept_items   = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int ready_pct    = 100;
    int pattern_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    scytale_transposition #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_char_in (i_char_in),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_char_out(o_char_out),
        .o_last_out(o_last_out)
    );

    scyt_text_checker #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_valid),
        .i_in_ready (o_ready),
        .i_in_char  (i_char_in),
        .i_out_valid(o_valid),
        .i_out_ready(i_ready),
        .i_out_char (o_char_out),
        .i_out_last (o_last_out),
        .o_errors   (fault_cnt),
        .o_pending  (pending_cnt)
    );

    // no transaction on either channel for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: stretches of random ready density, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_ready  <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 75;
                        2: ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                end
                pattern_left--;
                i_ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    function automatic int grid_size(input logic [scyt_pkg::DIM_W-1:0] r,
                                     input logic [scyt_pkg::DIM_W-1:0] c);
        int nr;
        int nc;
        nr = (r == '0) ? 1 : (int'(r) > MAX_ROWS) ? MAX_ROWS : int'(r);
        nc = (c == '0) ? 1 : (int'(c) > MAX_COLS) ? MAX_COLS : int'(c);
        return nr * nc;
    endfunction

    function automatic logic [scyt_pkg::DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 4) == 0)
            return scyt_pkg::DIM_W'($urandom_range(0, 15));
        return scyt_pkg::DIM_W'($urandom_range(0, 4));
    endfunction

    function automatic logic [scyt_pkg::CHAR_W-1:0] random_char();
        if ($urandom_range(0, 7) == 0)
            return scyt_pkg::SPACE_CHAR;
        return scyt_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic write_reg(input logic [scyt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [scyt_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_char(input logic [scyt_pkg::CHAR_W-1:0] ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gap_free ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_char_in <= ch;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (ch != scyt_pkg::SPACE_CHAR)
            kept_items++;
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // random text until the given number of non-space characters went in
    task automatic send_text(input int n_kept);
        int                          sent;
        logic [scyt_pkg::CHAR_W-1:0] ch;
        sent = 0;
        while (sent < n_kept) begin
            ch = random_char();
            send_char(ch);
            if (ch != scyt_pkg::SPACE_CHAR)
                sent++;
        end
    endtask

    // stop sending and let every predicted character come out
    task automatic drain_out();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [scyt_pkg::DIM_W-1:0] r,
                            input logic [scyt_pkg::DIM_W-1:0] c,
                            input logic m);
        logic [scyt_pkg::CFG_DATA_W-1:0] mode_word;
        drain_out();
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_UNUSED, scyt_pkg::CFG_DATA_W'($urandom_range(0, 15)));
        mode_word    = scyt_pkg::CFG_DATA_W'($urandom_range(0, 15));
        mode_word[0] = m;
        write_reg(scyt_pkg::CFG_ROWS, r);
        write_reg(scyt_pkg::CFG_COLS, c);
        write_reg(scyt_pkg::CFG_MODE, mode_word);
    endtask

    initial begin
        int                         phase;
        int                         total;
        int                         nblk;
        int                         b;
        logic [scyt_pkg::DIM_W-1:0] r;
        logic [scyt_pkg::DIM_W-1:0] c;
        logic                       m;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset shape is 1x1: every kept character is its own block
        send_char(8'h00);
        send_char(8'hFF);
        send_char(scyt_pkg::SPACE_CHAR);
        send_char(8'h5A);

        // oversized rows saturate, zero cols reads as one
        set_grid(4'd15, 4'd0, scyt_pkg::MODE_ENC);
        send_string("SCY TALE!");

        // a valid register write abandons a partial block, the unused index does not
        set_grid(4'd2, 4'd3, scyt_pkg::MODE_DEC);
        send_string("ab");
        drain_out();
        write_reg(scyt_pkg::CFG_ROWS, 4'd2);
        send_string("cd");
        drain_out();
        write_reg(CFG_UNUSED, 4'hF);
        send_string("efgh");

        // long output hold-off while input keeps coming, then a full drain
        set_grid(4'd3, 4'd2, scyt_pkg::MODE_ENC);
        hold_req = 1'b1;
        send_text(48);
        drain_out();

        phase = 0;
        while (kept_items < KEPT_TARGET) begin
            case (phase)
                0: begin
                    r    = 4'd15;
                    c    = 4'd15;
                    m    = scyt_pkg::MODE_ENC;
                    nblk = 1;
                end
                1: begin
                    r    = 4'd8;
                    c    = 4'd9;
                    m    = scyt_pkg::MODE_DEC;
                    nblk = 1;
                end
                default: begin
                    r    = pick_dim();
                    c    = pick_dim();
                    m    = 1'($urandom_range(0, 1));
                    nblk = $urandom_range(1, 4);
                end
            endcase
            total = grid_size(r, c);
            if (total > 16)
                nblk = 1;
            gap_free = ($urandom_range(0, 3) == 0);
            set_grid(r, c, m);
            for (b = 0; b < nblk; b++) begin
                send_text(total);
                if ($urandom_range(0, 3) == 0)
                    drain_out();
            end
            // leftover partial block, dropped by the next config write
            if (total > 1 && $urandom_range(0, 3) == 0)
                send_text($urandom_range(1, total - 1));
            phase++;
        end

        drain_out();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0 && pending_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/scyt_pkg.sv
rtl/scyt_ram.sv
rtl/scyt_front.sv
rtl/scyt_queue.sv
rtl/scyt_back.sv
rtl/scytale_transposition.sv
rtl/scyt_checker.sv
sim/scyt_text_checker.sv
sim/tb_scytale_transposition.sv
